// File: design/uos_pkg.sv
// Package: shared types, constants and index helpers for the ultimate oscillator.
package uos_pkg;

    localparam int PRICE_W    = 32;
    localparam int RING_DEPTH = 28;
    localparam int PTR_W      = 5;
    localparam int SUM_W      = 37;
    localparam int NUM_WIN    = 3;
    localparam int WIN_IDX_W  = 2;
    localparam int TERM_W     = 17;
    localparam int ACC_W      = 19;
    localparam int OUT_W      = 23;
    localparam int QUO_W      = TERM_W;
    localparam int STEP_W     = 5;
    localparam int REM_W      = SUM_W + 1;
    localparam int RECIP_W    = 28;
    localparam int SCALE_SHIFT = 24;

    localparam logic [PTR_W-1:0]   SHORT_WINDOW = PTR_W'(7);
    localparam logic [PTR_W-1:0]   MID_WINDOW   = PTR_W'(14);
    localparam logic [PTR_W-1:0]   LONG_WINDOW  = PTR_W'(28);
    localparam logic [TERM_W-1:0]  ONE_Q16      = TERM_W'(65536);
    localparam logic [RECIP_W-1:0] SCALE_RECIP  = RECIP_W'(239674515);
    localparam logic [STEP_W-1:0]  RATIO_STEPS  = STEP_W'(16);

    typedef struct packed {
        logic               series_start;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] oscillator_value;
        logic             zero_range_flag;
    } t_out_item;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  feed;
        logic [SUM_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    function automatic logic [PTR_W-1:0] win_len(input logic [WIN_IDX_W-1:0] k);
        logic [PTR_W-1:0] w;
        case (k)
            2'd0:    w = SHORT_WINDOW;
            2'd1:    w = MID_WINDOW;
            default: w = LONG_WINDOW;
        endcase
        return w;
    endfunction

    function automatic logic [PTR_W-1:0] leave_idx(input logic [PTR_W-1:0] wp,
                                                   input logic [WIN_IDX_W-1:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, wp} + (PTR_W+1)'(RING_DEPTH) - {1'b0, win_len(k)};
        if (s >= (PTR_W+1)'(RING_DEPTH)) begin
            s = s - (PTR_W+1)'(RING_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// File: design/uos_div.sv
// Restoring long divider, one quotient bit per cycle.
module uos_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  uos_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [uos_pkg::QUO_W-1:0] o_quo
);
    import uos_pkg::*;

    logic [REM_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]  r_feed, r_quo;
    logic [SUM_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [REM_W-1:0]  t;
    logic              take;

    always_comb begin
        t     = {r_rem[REM_W-2:0], r_feed[QUO_W-1]};
        take  = t >= {1'b0, r_den};
        n_rem = take ? (t - {1'b0, r_den}) : t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_req.rem;
                r_feed <= i_req.feed;
                r_den  <= i_req.den;
                r_quo  <= '0;
                r_cnt  <= i_req.steps;
            end else if (r_cnt != '0) begin
                r_rem  <= n_rem;
                r_feed <= {r_feed[QUO_W-2:0], 1'b0};
                r_quo  <= {r_quo[QUO_W-2:0], take};
                r_cnt  <= r_cnt - STEP_W'(1);
                r_done <= r_cnt == STEP_W'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: design/ultimate_oscillator_stream.sv
// Top level: ultimate oscillator over a stream of price bars.
//  channel | valid      | ready       | payload
//  in      | i_in_valid | o_in_ready  | i_in_data  (t_in_item)
//  out     | o_out_valid| i_out_ready | o_out_data (t_out_item)
// From its transfer in until the input is ready again, a bar passes the accept state,
// a ratio division in the shared divider for each window that needs one, the scale
// step, a ring read and a read wait per window, the ring write and the output load.
// A first bar skips the windows and the scale step.
// Reset and series_start clear the ring valid bits at once; no clearing pass.
// A finished result waits in the output register while the next bar is taken;
// the next result stalls in the output load until that register is free.
module ultimate_oscillator_stream (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  uos_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output uos_pkg::t_out_item o_out_data
);
    import uos_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WIN   = 4'd1;
    localparam logic [3:0] S_WDIV  = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_RDW   = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]             r_state;
    logic [PRICE_W-1:0]     r_prev_close;
    logic [PTR_W-1:0]       r_bar_cnt, r_wp;
    logic [RING_DEPTH-1:0]  r_vld;
    logic [SUM_W-1:0]       r_psum [NUM_WIN];
    logic [SUM_W-1:0]       r_tsum [NUM_WIN];
    logic [PRICE_W-1:0]     r_bp, r_tr;
    logic                   r_first;
    logic [WIN_IDX_W-1:0]   r_win;
    logic [ACC_W-1:0]       r_acc;
    logic                   r_flag;
    logic [OUT_W-1:0]       r_val;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [2*PRICE_W-1:0]   r_ring [RING_DEPTH];
    logic [2*PRICE_W-1:0]   r_rd_data;
    logic                   r_rd_vld;
    logic [PTR_W-1:0]       rd_addr;

    logic                   accept, start_eff, first_bar;
    logic [PRICE_W-1:0]     pc_eff, mn, mx;
    logic [SUM_W-1:0]       ps, ts;
    logic                   active;
    logic [ACC_W-1:0]       term_sh;
    logic [TERM_W-1:0]      term;
    logic [ACC_W+RECIP_W-1:0] scaled;
    logic                   div_start;
    t_div_req               div_req;
    logic                   div_done;
    logic [QUO_W-1:0]       div_quo;
    logic [PRICE_W-1:0]     lv_bp, lv_tr;

    uos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;
    assign start_eff  = i_in_data.series_start;
    assign first_bar  = start_eff || r_bar_cnt == '0;
    assign pc_eff     = start_eff ? '0 : r_prev_close;

    always_comb begin
        mn = (i_in_data.low_price < pc_eff) ? i_in_data.low_price : pc_eff;
        mx = (i_in_data.high_price > pc_eff) ? i_in_data.high_price : pc_eff;
        ps = r_psum[r_win];
        ts = r_tsum[r_win];
        active = r_bar_cnt >= win_len(r_win);
        term = '0;
        if (r_state == S_WDIV) begin
            term = div_quo[TERM_W-1:0];
        end else if (active && ts != '0 && ps >= ts) begin
            term = ONE_Q16;
        end
        term_sh = ACC_W'(term) << (2'd2 - r_win);
        scaled  = (ACC_W+RECIP_W)'(r_acc) * (ACC_W+RECIP_W)'(SCALE_RECIP);
        div_start = 1'b0;
        div_req   = '0;
        if (r_state == S_WIN && active && ts != '0 && ps < ts) begin
            div_start     = 1'b1;
            div_req.rem   = {1'b0, ps};
            div_req.den   = ts;
            div_req.steps = RATIO_STEPS;
        end
        rd_addr = leave_idx(r_wp, r_win);
        lv_bp = r_rd_vld ? r_rd_data[2*PRICE_W-1:PRICE_W] : '0;
        lv_tr = r_rd_vld ? r_rd_data[PRICE_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_ring[r_wp] <= {r_bp, r_tr};
        end
        r_rd_data <= r_ring[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_close <= '0;
            r_bar_cnt    <= '0;
            r_wp         <= '0;
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < NUM_WIN; k++) begin
                r_psum[k] <= '0;
                r_tsum[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (start_eff) begin
                            r_bar_cnt <= '0;
                            r_wp      <= '0;
                            r_vld     <= '0;
                            for (int k = 0; k < NUM_WIN; k++) begin
                                r_psum[k] <= '0;
                                r_tsum[k] <= '0;
                            end
                        end
                        r_first      <= first_bar;
                        r_bp         <= (!first_bar && i_in_data.close_price > mn) ?
                                        i_in_data.close_price - mn : '0;
                        r_tr         <= first_bar ? '0 : mx - mn;
                        r_prev_close <= i_in_data.close_price;
                        r_win        <= '0;
                        r_acc        <= '0;
                        r_flag       <= 1'b0;
                        r_val        <= '0;
                        r_state      <= first_bar ? S_RD : S_WIN;
                    end
                end
                S_WIN: begin
                    if (div_start) begin
                        r_state <= S_WDIV;
                    end else begin
                        if (active && ts == '0) begin
                            r_flag <= 1'b1;
                        end
                        r_acc <= r_acc + term_sh;
                        if (r_win == WIN_IDX_W'(NUM_WIN-1)) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_win <= r_win + WIN_IDX_W'(1);
                        end
                    end
                end
                S_WDIV: begin
                    if (div_done) begin
                        r_acc <= r_acc + term_sh;
                        if (r_win == WIN_IDX_W'(NUM_WIN-1)) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_win   <= r_win + WIN_IDX_W'(1);
                            r_state <= S_WIN;
                        end
                    end
                end
                S_SCALE: begin
                    r_val   <= scaled[SCALE_SHIFT +: OUT_W];
                    r_win   <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_psum[r_win] <= r_psum[r_win] + SUM_W'(r_bp) - SUM_W'(lv_bp);
                    r_tsum[r_win] <= r_tsum[r_win] + SUM_W'(r_tr) - SUM_W'(lv_tr);
                    if (r_win == WIN_IDX_W'(NUM_WIN-1)) begin
                        r_state <= S_WR;
                    end else begin
                        r_win   <= r_win + WIN_IDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_WR: begin
                    r_vld[r_wp] <= 1'b1;
                    r_wp <= (r_wp == PTR_W'(RING_DEPTH-1)) ? '0 : r_wp + PTR_W'(1);
                    if (r_bar_cnt < LONG_WINDOW) begin
                        r_bar_cnt <= r_bar_cnt + PTR_W'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.oscillator_value <= r_first ? '0 : r_val;
                        r_out.zero_range_flag  <= r_first ? 1'b0 : r_flag;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// File: tb/tb_ultimate_oscillator_stream.sv
// Testbench: ultimate oscillator stream checked against a built-in bar-by-bar predictor.
module tb_ultimate_oscillator_stream;
    import uos_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_RANDOM  = 425;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    ultimate_oscillator_stream dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    typedef struct {
        t_in_item  bar;
        logic      has_result;
        t_out_item result;
    } t_bar_row;

    t_out_item   osc_expected_q[$];
    t_in_item    bar_plan_q[$];
    t_bar_row    bar_rows[$];
    int          mismatches;
    int          cycle_count;
    logic        gaps_on;
    logic        hold_output;
    logic        bars_done;
    logic [31:0] prev_close;
    int          bars_seen;
    int          ring_ptr;
    logic [31:0] bp_ring[RING_DEPTH];
    logic [31:0] tr_ring[RING_DEPTH];
    logic [63:0] bp_sum[3];
    logic [63:0] tr_sum[3];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("ultimate_oscillator_stream verification failed");
                $finish;
            end
        end
    end

    function automatic int window_of(input int k);
        return (k == 0) ? int'(SHORT_WINDOW) : (k == 1) ? int'(MID_WINDOW) : int'(LONG_WINDOW);
    endfunction

    function automatic logic [16:0] ratio_of(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [16:0] q;
        if (num >= den) return ONE_Q16;
        rem = num;
        q = '0;
        for (int k = 0; k < 16; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic void clear_history();
        prev_close = '0;
        bars_seen = 0;
        ring_ptr = 0;
        for (int k = 0; k < RING_DEPTH; k++) begin
            bp_ring[k] = '0;
            tr_ring[k] = '0;
        end
        for (int k = 0; k < 3; k++) begin
            bp_sum[k] = '0;
            tr_sum[k] = '0;
        end
    endfunction

    function automatic void push_bar_entry(input logic [31:0] bp, input logic [31:0] tr);
        int leave;
        for (int k = 0; k < 3; k++) begin
            leave = (ring_ptr + RING_DEPTH - window_of(k)) % RING_DEPTH;
            bp_sum[k] = bp_sum[k] + bp - bp_ring[leave];
            tr_sum[k] = tr_sum[k] + tr - tr_ring[leave];
        end
        bp_ring[ring_ptr] = bp;
        tr_ring[ring_ptr] = tr;
        ring_ptr = (ring_ptr + 1) % RING_DEPTH;
        if (bars_seen < RING_DEPTH) bars_seen++;
    endfunction

    function automatic t_out_item predict_oscillator(input t_in_item bar);
        t_out_item   res;
        logic [31:0] lo_edge, hi_edge, bp, tr;
        logic [16:0] term[3];
        logic [63:0] val;
        res = '0;
        if (bar.series_start) clear_history();
        if (bars_seen == 0) begin
            push_bar_entry('0, '0);
            prev_close = bar.close_price;
            return res;
        end
        lo_edge = (bar.low_price < prev_close) ? bar.low_price : prev_close;
        hi_edge = (bar.high_price > prev_close) ? bar.high_price : prev_close;
        bp = (bar.close_price > lo_edge) ? bar.close_price - lo_edge : '0;
        tr = hi_edge - lo_edge;
        for (int k = 0; k < 3; k++) begin
            term[k] = '0;
            if (bars_seen >= window_of(k)) begin
                if (tr_sum[k] == 0) res.zero_range_flag = 1'b1;
                else term[k] = ratio_of(bp_sum[k], tr_sum[k]);
            end
        end
        val = (64'd100 * (64'd4 * term[0] + 64'd2 * term[1] + 64'(term[2]))) / 64'd7;
        if (val > 64'd6553600) val = 64'd6553600;
        res.oscillator_value = val[OUT_W-1:0];
        push_bar_entry(bp, tr);
        prev_close = bar.close_price;
        return res;
    endfunction

    function automatic t_in_item make_bar(input logic s, input logic [31:0] h,
                                          input logic [31:0] l, input logic [31:0] c);
        t_in_item b;
        b.series_start = s;
        b.high_price = h;
        b.low_price = l;
        b.close_price = c;
        return b;
    endfunction

    function automatic t_bar_row make_row(input t_in_item b, input logic known,
                                          input logic [OUT_W-1:0] v, input logic f);
        t_bar_row r;
        r.bar = b;
        r.has_result = known;
        r.result.oscillator_value = v;
        r.result.zero_range_flag = f;
        return r;
    endfunction

    function automatic logic [31:0] rand_price(input logic [31:0] base, input int spread);
        return base + $urandom_range(0, spread) - spread / 2;
    endfunction

    task automatic plan_bars();
        logic [31:0] base;
        int          run;
        t_in_item    b;
        // after reset, extremes, flat bars (zero range), close outside range
        bar_rows.push_back(make_row(make_bar(1'b0, 32'h0001_0000, 32'h0000_8000,
                                             32'h0000_C000), 1'b1, '0, 1'b0));
        bar_rows.push_back(make_row(make_bar(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF),
                                    1'b1, '0, 1'b0));
        bar_rows.push_back(make_row(make_bar(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0),
                                    1'b0, '0, 1'b0));
        bar_rows.push_back(make_row(make_bar(1'b1, 32'h5, 32'h5, 32'h5), 1'b1, '0, 1'b0));
        for (int k = 0; k < 8; k++)
            bar_rows.push_back(make_row(make_bar(1'b0, 32'h5, 32'h5, 32'h5),
                                        (k == 7), '0, 1'b1));
        bar_rows.push_back(make_row(make_bar(1'b0, 32'h10, 32'h1, 32'hFFFF_FFFF),
                                    1'b0, '0, 1'b0));
        bar_rows.push_back(make_row(make_bar(1'b0, 32'h10, 32'h8, 32'h0), 1'b0, '0, 1'b0));
        bar_rows.push_back(make_row(make_bar(1'b0, 32'hAAAA_AAAA, 32'h5555_5555,
                                             32'h8000_0000), 1'b0, '0, 1'b0));
        bar_rows.push_back(make_row(make_bar(1'b0, 32'h5555_5555, 32'hAAAA_AAAA,
                                             32'h7FFF_FFFF), 1'b0, '0, 1'b0));
        for (int k = 0; k < 9; k++)
            bar_rows.push_back(make_row(make_bar(1'b0, 32'h8000 + k, 32'h4000,
                                                 32'h6000 + k * 100), 1'b0, '0, 1'b0));

        base = $urandom;
        run = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (run == 0) begin
                run = $urandom_range(10, 70);
                base = $urandom;
                b = make_bar(1'b1, base, base, base);
            end else begin
                b.series_start = ($urandom_range(0, 99) < 2);
            end
            case ($urandom_range(0, 9))
                0: begin
                    b.high_price = $urandom;
                    b.low_price = $urandom;
                    b.close_price = $urandom;
                end
                1: begin
                    b.high_price = base;
                    b.low_price = base;
                    b.close_price = base;
                end
                default: begin
                    base = rand_price(base, 32'h40000);
                    b.high_price = rand_price(base, 32'h20000) + 32'h10000;
                    b.low_price = rand_price(base, 32'h20000) - 32'h10000;
                    b.close_price = rand_price(base, 32'h30000);
                end
            endcase
            run--;
            bar_rows.push_back(make_row(b, 1'b0, '0, 1'b0));
        end
    endtask

    // sender
    initial begin
        t_bar_row  row;
        t_out_item predicted;
        int        stall_cycle;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_rst_n = 1'b0;
        mismatches = 0;
        bars_done = 1'b0;
        gaps_on = 1'b1;
        clear_history();
        plan_bars();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (bar_rows[n]) begin
            row = bar_rows[n];
            gaps_on = !(n >= 150 && n < 230);
            while (gaps_on && $urandom_range(0, 99) < 26) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            predicted = predict_oscillator(row.bar);
            if (row.has_result && predicted !== row.result) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: table %h predictor %h", n, row.result, predicted);
            end
            osc_expected_q.push_back(row.has_result ? row.result : predicted);
            i_in_valid <= 1'b1;
            i_in_data <= row.bar;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
        bars_done = 1'b1;
    end

    // receiver hold-off
    initial begin
        hold_output = 1'b0;
        wait (bar_rows.size() > 60 && i_rst_n === 1'b1);
        repeat (3000) @(posedge i_clk);
        hold_output = 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_output = 1'b0;
    end

    // receiver
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (osc_expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer %h", o_out_data);
                end else if (o_out_data.oscillator_value !==
                             osc_expected_q[0].oscillator_value ||
                             o_out_data.zero_range_flag !==
                             osc_expected_q[0].zero_range_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%b actual %0d/%b",
                                 osc_expected_q[0].oscillator_value,
                                 osc_expected_q[0].zero_range_flag,
                                 o_out_data.oscillator_value, o_out_data.zero_range_flag);
                    void'(osc_expected_q.pop_front());
                end else begin
                    void'(osc_expected_q.pop_front());
                end
            end
            i_out_ready <= !hold_output && !(gaps_on && $urandom_range(0, 99) < 26);
        end
    end

    initial begin
        wait (bars_done === 1'b1);
        wait (osc_expected_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && osc_expected_q.size() == 0) begin
            $display("ultimate_oscillator_stream verification clean");
        end else begin
            $display("ultimate_oscillator_stream verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
design/uos_pkg.sv
design/uos_div.sv
design/ultimate_oscillator_stream.sv
tb/tb_ultimate_oscillator_stream.sv
